FILE: sv/mpps_pkg.sv
// ----------------------------------------------------------------------------
// mpps_pkg
// Shared types, constants and helpers for the merge-path partition start block.
// ----------------------------------------------------------------------------
package mpps_pkg;

    // Default width of the nonzero and row counters.
    localparam int INDEX_BITS_DEFAULT = 32;

    // Field widths fixed by the interface.
    localparam int ROW_IN_BITS = 32;
    localparam int OUT_BITS    = 32;
    localparam int WS_BITS     = 21;

    // Reset value of the partition size register.
    localparam logic [WS_BITS-1:0] PART_SIZE_RESET = 21'd256;

    // Queue depths; both must be powers of two so the pointers wrap on their own.
    localparam int CMD_DEPTH   = 4;
    localparam int RES_DEPTH   = 8;
    localparam int MAX_RESULTS = 3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_PART_SIZE = 1'b0
    } reg_index_t;

    // One input beat.
    typedef struct packed {
        logic [ROW_IN_BITS-1:0] row_index;
        logic                   last_nonzero;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [OUT_BITS-1:0] begin_nz;
        logic                is_last;
    } result_t;

    // Classified item handed from the front to the walk.
    typedef struct packed {
        logic row_change;
        logic last;
    } cmd_t;

    // Up to three results produced by one item, oldest in slot 0.
    typedef struct packed {
        logic [1:0]                 count;
        result_t [MAX_RESULTS-1:0]  slot;
    } burst_t;

    // Clamp a wide count to the 32-bit result field.
    function automatic logic [OUT_BITS-1:0] sat_out(input logic [63:0] value);
        logic [OUT_BITS-1:0] clamped;
        if (value > 64'h0000_0000_FFFF_FFFF)
        begin
            clamped = '1;
        end
        else
        begin
            clamped = value[OUT_BITS-1:0];
        end
        return clamped;
    endfunction

endpackage

FILE: sv/mpps_front.sv
// ----------------------------------------------------------------------------
// mpps_front
// Accepts nonzero beats and marks each one as a row change and/or the last.
// ----------------------------------------------------------------------------
module mpps_front #(
    parameter int INDEX_BITS = mpps_pkg::INDEX_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mpps_pkg::item_t item,
    output logic            full,
    input  logic            cmd_full,
    output logic            cmd_push,
    output mpps_pkg::cmd_t  cmd
);

    // Rows are compared on their low bits only.
    localparam int ROW_BITS = (INDEX_BITS < mpps_pkg::ROW_IN_BITS) ?
                              INDEX_BITS : mpps_pkg::ROW_IN_BITS;

    logic [ROW_BITS-1:0] prev_row_reg, prev_row_next;
    logic                any_seen_reg, any_seen_next;
    logic [ROW_BITS-1:0] row;

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;
    assign row      = item.row_index[ROW_BITS-1:0];

    // Classify the beat against the previous row of the current walk.
    always_comb
    begin
        cmd.row_change = any_seen_reg && (row != prev_row_reg);
        cmd.last       = item.last_nonzero;
        prev_row_next  = prev_row_reg;
        any_seen_next  = any_seen_reg;
        if (cmd_push)
        begin
            prev_row_next = row;
            any_seen_next = !item.last_nonzero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_row_reg <= '0;
            any_seen_reg <= 1'b0;
        end
        else
        begin
            prev_row_reg <= prev_row_next;
            any_seen_reg <= any_seen_next;
        end
    end

endmodule

FILE: sv/mpps_cmd_queue.sv
// ----------------------------------------------------------------------------
// mpps_cmd_queue
// Short queue of classified items between the front and the walk.
// ----------------------------------------------------------------------------
module mpps_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mpps_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output mpps_pkg::cmd_t dout
);

    localparam int DEPTH    = mpps_pkg::CMD_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    mpps_pkg::cmd_t      mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill level update.
    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

FILE: sv/mpps_walk.sv
// ----------------------------------------------------------------------------
// mpps_walk
// Walks the merge path for one item per cycle while the result queue has room: a boundary
// step on a row change, one nonzero step, and the closing count on the last item.
// ----------------------------------------------------------------------------
module mpps_walk #(
    parameter int INDEX_BITS = mpps_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    input  mpps_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    input  logic [mpps_pkg::WS_BITS-1:0]  part_size,
    input  logic                          space_ok,
    output mpps_pkg::burst_t              burst
);

    localparam int CNT_BITS  = INDEX_BITS;
    localparam int POS_BITS  = INDEX_BITS + 1;
    localparam int DIAG_BITS = ((POS_BITS > mpps_pkg::WS_BITS) ?
                                POS_BITS : mpps_pkg::WS_BITS) + 1;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [CNT_BITS-1:0]  nz_reg, nz_next;
    logic [CNT_BITS-1:0]  rows_reg, rows_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [DIAG_BITS-1:0] diag_reg, diag_next;

    logic [mpps_pkg::WS_BITS-1:0] ws_eff;
    logic                 ws_one;
    logic [CNT_BITS-1:0]  rows_new, nz_new;
    logic [POS_BITS-1:0]  pos_inc, pos_inc2, pos_b, pos_after, rows_ext;
    logic [POS_BITS-1:0]  val_a, val_b;
    logic                 eq_a, eq_a1;
    logic                 step_a, emit_a, step_b, emit_b;
    logic [DIAG_BITS-1:0] diag_step;

    assign cmd_pop = !cmd_empty && space_ok;

    // Per-item step decisions; both steps are resolved from the current state.
    always_comb
    begin
        ws_eff   = (part_size == '0) ? mpps_pkg::WS_BITS'(1) : part_size;
        ws_one   = (ws_eff == mpps_pkg::WS_BITS'(1));
        rows_new = (cmd.row_change && rows_reg != CNT_MAX) ? rows_reg + 1'b1 : rows_reg;
        nz_new   = (nz_reg != CNT_MAX) ? nz_reg + 1'b1 : nz_reg;
        rows_ext = POS_BITS'(rows_new);
        pos_inc  = pos_reg + POS_BITS'(1);
        pos_inc2 = pos_reg + POS_BITS'(2);
        eq_a     = (DIAG_BITS'(pos_reg) == diag_reg);
        eq_a1    = (DIAG_BITS'(pos_inc) == diag_reg);

        // Boundary step ahead of the first nonzero of a new row.
        step_a = cmd.row_change && (pos_reg != POS_MAX);
        emit_a = step_a && eq_a;
        pos_b  = step_a ? pos_inc : pos_reg;

        // Nonzero step; after a boundary hit the next diagonal is one partition on.
        step_b = (pos_b != POS_MAX);
        if (emit_a)
        begin
            emit_b = step_b && ws_one;
        end
        else if (step_a)
        begin
            emit_b = step_b && eq_a1;
        end
        else
        begin
            emit_b = step_b && eq_a;
        end

        if (!step_b)
        begin
            pos_after = pos_b;
        end
        else if (step_a)
        begin
            pos_after = pos_inc2;
        end
        else
        begin
            pos_after = pos_inc;
        end

        val_a = (rows_ext > pos_reg) ? '0 : pos_reg - rows_ext;
        val_b = (rows_ext > pos_b) ? '0 : pos_b - rows_ext;

        if (emit_a && emit_b)
        begin
            diag_step = DIAG_BITS'(2);
        end
        else if (emit_a || emit_b)
        begin
            diag_step = DIAG_BITS'(ws_eff);
        end
        else
        begin
            diag_step = '0;
        end
    end

    // Pack the results of this item, oldest first.
    always_comb
    begin
        logic [1:0] k;
        k           = 2'd0;
        burst.slot  = '0;
        if (cmd_pop && emit_a)
        begin
            burst.slot[k].begin_nz = mpps_pkg::sat_out(64'(val_a));
            burst.slot[k].is_last  = 1'b0;
            k = k + 2'd1;
        end
        if (cmd_pop && emit_b)
        begin
            burst.slot[k].begin_nz = mpps_pkg::sat_out(64'(val_b));
            burst.slot[k].is_last  = 1'b0;
            k = k + 2'd1;
        end
        if (cmd_pop && cmd.last)
        begin
            burst.slot[k].begin_nz = mpps_pkg::sat_out(64'(nz_new));
            burst.slot[k].is_last  = 1'b1;
            k = k + 2'd1;
        end
        burst.count = k;
    end

    // Walk state; the closing item returns it to the start.
    always_comb
    begin
        nz_next   = nz_reg;
        rows_next = rows_reg;
        pos_next  = pos_reg;
        diag_next = diag_reg;
        if (cmd_pop)
        begin
            if (cmd.last)
            begin
                nz_next   = '0;
                rows_next = '0;
                pos_next  = '0;
                diag_next = '0;
            end
            else
            begin
                nz_next   = nz_new;
                rows_next = rows_new;
                pos_next  = pos_after;
                diag_next = diag_reg + diag_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg   <= '0;
            rows_reg <= '0;
            pos_reg  <= '0;
            diag_reg <= '0;
        end
        else
        begin
            nz_reg   <= nz_next;
            rows_reg <= rows_next;
            pos_reg  <= pos_next;
            diag_reg <= diag_next;
        end
    end

endmodule

FILE: sv/mpps_result_queue.sv
// ----------------------------------------------------------------------------
// mpps_result_queue
// Result queue that takes up to three beats per cycle and hands out one.
// ----------------------------------------------------------------------------
module mpps_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  mpps_pkg::burst_t    burst,
    output logic                space_ok,
    input  logic                pop,
    output logic                empty,
    output mpps_pkg::result_t   result
);

    localparam int DEPTH    = mpps_pkg::RES_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    mpps_pkg::result_t   mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_pop;

    assign empty    = (count_reg == '0);
    assign result   = mem_reg[rptr_reg];
    assign do_pop   = pop && !empty;
    assign space_ok = (count_reg <= CNT_BITS'(DEPTH - mpps_pkg::MAX_RESULTS));

    // Pointers advance by the burst size on write and by one on read.
    always_comb
    begin
        wptr_next  = wptr_reg + PTR_BITS'(burst.count);
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + CNT_BITS'(burst.count) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage: each slot of the burst lands at its own offset from the write pointer.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mpps_pkg::MAX_RESULTS; i++)
        begin
            if (2'(i) < burst.count)
            begin
                mem_reg[wptr_reg + PTR_BITS'(i)] <= burst.slot[i];
            end
        end
    end

endmodule

FILE: sv/merge_path_partition_starts.sv
// Path: an accepted item is registered in the command queue, its results in the result queue.
// Throughput: one item per cycle while the result queue has room for a full burst; each item
//   gives zero to three results, and results leave one per cycle through the single result
//   port, which sets the sustained rate when partitions are short.
// Reset: rst_n clears the walk and both queues and sets the partition size to 256.
// ----------------------------------------------------------------------------
// merge_path_partition_starts
// Emits the starting nonzero index of every merge-path partition of a sparse
// matrix, then the total nonzero count, from a stream of row indices.
// ----------------------------------------------------------------------------
module merge_path_partition_starts #(
    parameter int INDEX_BITS = mpps_pkg::INDEX_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    // Item queue side.
    input  logic               push,
    output logic               full,
    input  mpps_pkg::item_t    item,
    // Result queue side.
    output logic               empty,
    input  logic               pop,
    output mpps_pkg::result_t  result,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [mpps_pkg::WS_BITS-1:0] part_size_reg, part_size_next;
    mpps_pkg::reg_index_t         reg_index;
    logic                         cfg_write;

    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    mpps_pkg::cmd_t   cmd_in, cmd_out;
    mpps_pkg::burst_t burst;
    logic             space_ok;

    // Configuration register.
    assign pready    = 1'b1;
    assign reg_index = mpps_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        part_size_next = part_size_reg;
        prdata         = '0;
        unique case (reg_index)
            mpps_pkg::REG_PART_SIZE:
            begin
                prdata = 32'(part_size_reg);
                if (cfg_write)
                begin
                    part_size_next = pwdata[mpps_pkg::WS_BITS-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_size_reg <= mpps_pkg::PART_SIZE_RESET;
        end
        else
        begin
            part_size_reg <= part_size_next;
        end
    end

    // Front: accept and classify.
    mpps_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // Queue between front and walk.
    mpps_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (cmd_out)
    );

    // Back: walk the path.
    mpps_walk #(
        .INDEX_BITS (INDEX_BITS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .part_size (part_size_reg),
        .space_ok  (space_ok),
        .burst     (burst)
    );

    // Result queue.
    mpps_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .burst    (burst),
        .space_ok (space_ok),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

`ifndef NO_ASSERTIONS
    // Results are only produced while the walk takes an item.
    a_burst_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (burst.count != 2'd0) |-> cmd_pop)
        else $error("results produced without an item");

    // A burst is only written when the result queue has room for a full one.
    a_burst_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (burst.count != 2'd0) |-> space_ok)
        else $error("result queue overrun");

    // A waiting result that is not taken stays available.
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped");
`endif

endmodule

FILE: sim/tb_merge_path_partition_starts.sv
// ----------------------------------------------------------------------------
// tb_merge_path_partition_starts
// Self-checking bench for the merge-path partition start block. A directed
// table covers reset state, partition size extremes and row changes both
// ways, then random matrices run over several partition sizes. Every result
// beat is compared with a typed expectation or a behavioral walk prediction.
// ----------------------------------------------------------------------------
module tb_merge_path_partition_starts;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDX        = mpps_pkg::INDEX_BITS_DEFAULT;
    localparam logic [63:0] CNT_MAX    = (64'd1 << IDX) - 64'd1;
    localparam logic [63:0] POS_MAX    = (64'd1 << (IDX + 1)) - 64'd1;
    localparam int          IDLE_LIMIT = 2000;

    // One entry of the directed stimulus table.
    typedef struct packed {
        bit                      is_cfg;
        bit                      typed;
        logic [1:0]              n_typed;
        logic [31:0]             cfg_value;
        mpps_pkg::item_t         beat;
        mpps_pkg::result_t [2:0] want;
    } stim_row_t;

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              push    = 1'b0;
    logic              full;
    mpps_pkg::item_t   nz_beat = '0;
    logic              empty;
    logic              pop     = 1'b0;
    mpps_pkg::result_t part_beat;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Shared bench state.
    bit                no_idle = 1'b0;
    int                mismatches = 0;
    int                items_sent = 0;
    int                starts_checked = 0;
    int                cfg_writes = 0;
    int                idle_cycles = 0;
    mpps_pkg::result_t expected_starts [$];
    stim_row_t         stim_rows [$];

    // Predicted walk state.
    logic [63:0]       ws_reg;
    logic [63:0]       nonzeros_seen;
    logic [63:0]       path_pos;
    logic [63:0]       next_diag;
    logic [63:0]       rows_begun;
    logic [63:0]       prev_row;
    bit                any_seen;
    mpps_pkg::result_t pred_out [3];

    merge_path_partition_starts dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (nz_beat),
        .empty   (empty),
        .pop     (pop),
        .result  (part_beat),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch: %s expected %0h got %0h", what, want, got);
        end
    endtask

    // Walk state returns to its start after reset and after each closing count.
    function automatic void clear_walk();
        nonzeros_seen = '0;
        path_pos      = '0;
        next_diag     = '0;
        rows_begun    = '0;
        prev_row      = '0;
        any_seen      = 1'b0;
    endfunction

    // One path step; lands a partition start in slot k when it hits a diagonal.
    function automatic int advance_path(input int k);
        logic [63:0] step_ws;
        logic [63:0] nz_index;
        step_ws = (ws_reg == 64'd0) ? 64'd1 : ws_reg;
        if (path_pos >= POS_MAX)
        begin
            return 0;
        end
        if (path_pos == next_diag)
        begin
            nz_index = (rows_begun > path_pos) ? 64'd0 : path_pos - rows_begun;
            pred_out[k].begin_nz = (nz_index > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                               : nz_index[31:0];
            pred_out[k].is_last  = 1'b0;
            next_diag = next_diag + step_ws;
            path_pos  = path_pos + 64'd1;
            return 1;
        end
        path_pos = path_pos + 64'd1;
        return 0;
    endfunction

    // Partition starts caused by one nonzero, oldest in slot 0.
    function automatic int predict_starts(input mpps_pkg::item_t b);
        logic [63:0] row;
        int          k;
        row = {32'd0, b.row_index} & CNT_MAX;
        k   = 0;
        // Any change of row, up or down, opens a new row with a boundary step.
        if (any_seen && row != prev_row)
        begin
            if (rows_begun < CNT_MAX)
            begin
                rows_begun = rows_begun + 64'd1;
            end
            k += advance_path(k);
        end
        k += advance_path(k);
        if (nonzeros_seen < CNT_MAX)
        begin
            nonzeros_seen = nonzeros_seen + 64'd1;
        end
        prev_row = row;
        any_seen = 1'b1;
        // The closing beat carries the total count.
        if (b.last_nonzero)
        begin
            pred_out[k].begin_nz = (nonzeros_seen > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                    : nonzeros_seen[31:0];
            pred_out[k].is_last  = 1'b1;
            k++;
            clear_walk();
        end
        return k;
    endfunction

    function automatic mpps_pkg::result_t rb(input logic [31:0] v, input bit l);
        mpps_pkg::result_t r;
        r.begin_nz = v;
        r.is_last  = l;
        return r;
    endfunction

    task automatic add_cfg(input logic [31:0] v);
        stim_row_t r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.cfg_value = v;
        stim_rows   = {stim_rows, r};
    endtask

    // n < 0 leaves the row to the predictor; otherwise the n results are typed in.
    task automatic add_nz(input logic [31:0] row, input bit l, input int n,
                          input mpps_pkg::result_t w0 = '0,
                          input mpps_pkg::result_t w1 = '0,
                          input mpps_pkg::result_t w2 = '0);
        stim_row_t r;
        r                   = '0;
        r.beat.row_index    = row;
        r.beat.last_nonzero = l;
        r.typed             = (n >= 0);
        r.n_typed           = (n >= 0) ? n[1:0] : 2'd0;
        r.want[0]           = w0;
        r.want[1]           = w1;
        r.want[2]           = w2;
        stim_rows           = {stim_rows, r};
    endtask

    // Present one beat after a random gap and hold it until accepted.
    task automatic send_nz(input mpps_pkg::item_t b);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        nz_beat <= b;
        do @(posedge clk); while (full);
    endtask

    // Book the results of an accepted beat.
    task automatic take_beat(input mpps_pkg::item_t b, input bit typed, input int n,
                             input mpps_pkg::result_t [2:0] want);
        int cnt;
        cnt = predict_starts(b);
        if (typed)
        begin
            for (int i = 0; i < n; i++)
            begin
                expected_starts = {expected_starts, want[i]};
            end
        end
        else
        begin
            for (int i = 0; i < cnt; i++)
            begin
                expected_starts = {expected_starts, pred_out[i]};
            end
        end
        items_sent++;
    endtask

    // Stop sending and let every expected result come out, plus some slack.
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_starts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {mpps_pkg::REG_PART_SIZE, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            report_mismatch("part_size readback", {32'd0, want}, {32'd0, prdata});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the partition size, mirror it in the predictor and read it back.
    task automatic program_part_size(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mpps_pkg::REG_PART_SIZE, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        ws_reg = {43'd0, v[mpps_pkg::WS_BITS-1:0]};
        cfg_writes++;
        @(posedge clk);
        apb_read_check({11'd0, v[mpps_pkg::WS_BITS-1:0]});
    endtask

    // Result side: random stalls, with bursts of pops in between.
    initial
    begin
        int stall;
        int burst;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : pick_gap();
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop   <= 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst) @(posedge clk);
        end
    end

    // Compare each popped beat with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        mpps_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            starts_checked++;
            if (expected_starts.size() == 0)
            begin
                report_mismatch("result beat with none expected", 64'd0,
                                {31'd0, part_beat});
            end
            else
            begin
                want = expected_starts.pop_front();
                if (part_beat.begin_nz !== want.begin_nz)
                begin
                    report_mismatch("begin_nz", {32'd0, want.begin_nz},
                                    {32'd0, part_beat.begin_nz});
                end
                if (part_beat.is_last !== want.is_last)
                begin
                    report_mismatch("is_last", {63'd0, want.is_last},
                                    {63'd0, part_beat.is_last});
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", IDLE_LIMIT);
            $display("tb_merge_path_partition_starts: done, errors");
            $finish;
        end
    end

    // Main stimulus.
    initial
    begin
        mpps_pkg::item_t b;
        stim_row_t       r;
        logic [31:0]     row;
        logic [31:0]     phase_ws [6];
        int              len;
        int              pick;
        int              in_phase;
        bit              keep_open;

        ws_reg = {43'd0, mpps_pkg::PART_SIZE_RESET};
        clear_walk();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        apb_read_check({11'd0, mpps_pkg::PART_SIZE_RESET});

        // Directed table. Reset partition size first: one beat gives a start and the count.
        add_nz(32'd0, 1'b1, 2, rb(32'd0, 1'b0), rb(32'd1, 1'b1));
        // Smallest partition size: every path position is a partition start.
        add_cfg(32'd1);
        add_nz(32'd0, 1'b0, 1, rb(32'd0, 1'b0));
        add_nz(32'd0, 1'b0, 1, rb(32'd1, 1'b0));
        add_nz(32'd5, 1'b0, 2, rb(32'd1, 1'b0), rb(32'd2, 1'b0));
        add_nz(32'd3, 1'b1, 3, rb(32'd2, 1'b0), rb(32'd3, 1'b0), rb(32'd4, 1'b1));
        add_nz(32'hFFFF_FFFF, 1'b0, 1, rb(32'd0, 1'b0));
        add_nz(32'd0, 1'b1, 3, rb(32'd0, 1'b0), rb(32'd1, 1'b0), rb(32'd2, 1'b1));
        // Zero partition size behaves like one.
        add_cfg(32'd0);
        add_nz(32'd2, 1'b0, 1, rb(32'd0, 1'b0));
        add_nz(32'd2, 1'b0, 1, rb(32'd1, 1'b0));
        add_nz(32'd2, 1'b1, 2, rb(32'd2, 1'b0), rb(32'd3, 1'b1));
        // Mixed rows at a small partition size, left to the predictor.
        add_cfg(32'd3);
        add_nz(32'd10, 1'b0, -1);
        add_nz(32'd10, 1'b0, -1);
        add_nz(32'd11, 1'b0, -1);
        add_nz(32'd11, 1'b0, -1);
        add_nz(32'd11, 1'b0, -1);
        add_nz(32'd40, 1'b0, -1);
        add_nz(32'd40, 1'b0, -1);
        add_nz(32'd12, 1'b1, -1);
        // Partition size 2^20: only position zero and the count.
        add_cfg(32'h0010_0000);
        add_nz(32'd7, 1'b0, 1, rb(32'd0, 1'b0));
        add_nz(32'd7, 1'b0, 0);
        add_nz(32'd8, 1'b1, 1, rb(32'd3, 1'b1));
        // All ones on the bus; only the low 21 bits land in the register.
        add_cfg(32'hFFFF_FFFF);
        add_nz(32'hFFFF_FFFF, 1'b0, 1, rb(32'd0, 1'b0));
        add_nz(32'hFFFF_FFFF, 1'b1, 1, rb(32'd2, 1'b1));

        foreach (stim_rows[i])
        begin
            r = stim_rows[i];
            if (r.is_cfg)
            begin
                wait_drained();
                program_part_size(r.cfg_value);
            end
            else
            begin
                send_nz(r.beat);
                take_beat(r.beat, r.typed, r.n_typed, r.want);
            end
        end

        // Random matrices over several partition sizes.
        phase_ws = '{32'd2, 32'd1, 32'd4, 32'd0, 32'd3, 32'd7};
        phase_ws[5] = $urandom_range(5, 12);
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            program_part_size(phase_ws[ph]);
            no_idle  = (ph == 2) || (ph == 5);
            in_phase = 0;
            while (in_phase < 14)
            begin
                len       = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                        : $urandom_range(1, 8);
                keep_open = ($urandom_range(0, 9) == 0);
                row       = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20);
                for (int k = 0; k < len; k++)
                begin
                    // Mostly ordered rows; a few jumps anywhere or a step back.
                    if (k > 0)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick >= 55 && pick < 80)
                        begin
                            row = row + 32'd1;
                        end
                        else if (pick >= 80 && pick < 90)
                        begin
                            row = row + $urandom_range(2, 1000);
                        end
                        else if (pick >= 90 && pick < 95)
                        begin
                            row = $urandom;
                        end
                        else if (pick >= 95)
                        begin
                            row = row - 32'd1;
                        end
                    end
                    b.row_index    = row;
                    b.last_nonzero = (k == len - 1) && !keep_open;
                    send_nz(b);
                    take_beat(b, 1'b0, 0, '0);
                    in_phase++;
                end
            end
        end

        no_idle = 1'b0;
        wait_drained();
        if (expected_starts.size() != 0)
        begin
            report_mismatch("results left over", 64'd0, 64'(expected_starts.size()));
        end

        $display("covered %0d nonzero beats, %0d result beats, %0d part_size writes",
                 items_sent, starts_checked, cfg_writes);
        $display("partition sizes included zero, one, the 21-bit maximum and masked writes");
        if (mismatches == 0)
        begin
            $display("tb_merge_path_partition_starts: done, clean");
        end
        else
        begin
            $display("tb_merge_path_partition_starts: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/mpps_pkg.sv
sv/mpps_front.sv
sv/mpps_cmd_queue.sv
sv/mpps_walk.sv
sv/mpps_result_queue.sv
sv/merge_path_partition_starts.sv
sim/tb_merge_path_partition_starts.sv
